### design/feed_sequence_gap_tracker_core_assert.svh
// Assertion macros for the sequence gap tracker
`ifndef FEED_SEQUENCE_GAP_TRACKER_CORE_ASSERT_SVH
`define FEED_SEQUENCE_GAP_TRACKER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, off while rst_n is low
`define FSGT_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsgt: assertion failed");

// next-cycle implication
`define FSGT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsgt: assertion failed");

`else

`define FSGT_ASSERT_IMPL(name, ante, cons)
`define FSGT_ASSERT_NEXT(name, ante, cons)

`endif

`endif

### design/fsgt_pkg.sv
// Types and codes shared by the sequence gap tracker files
package fsgt_pkg;

    typedef enum logic [2:0] {
        OP_SUBSCRIBE    = 3'd0,
        OP_UNSUBSCRIBE  = 3'd1,
        OP_SNAPSHOT     = 3'd2,
        OP_INCREMENTAL  = 3'd3,
        OP_RESYNC_BEGIN = 3'd4,
        OP_RESYNC_END   = 3'd5,
        OP_QUERY        = 3'd6
    } opcode_t;

    typedef enum logic [1:0] {
        DEC_NONE    = 2'd0,
        DEC_IGNORED = 2'd1,
        DEC_RESYNC  = 2'd2,
        DEC_APPLIED = 2'd3
    } decision_t;

    typedef enum logic [2:0] {
        RSN_NONE         = 3'd0,
        RSN_NOT_SUBSCR   = 3'd1,
        RSN_NO_SNAPSHOT  = 3'd2,
        RSN_OUT_OF_ORDER = 3'd3,
        RSN_GAP          = 3'd4,
        RSN_APPLY_FAILED = 3'd5,
        RSN_APPLIED      = 3'd6
    } reason_t;

    localparam int DEPTH_W = 16;
    localparam int SEQ_W   = 32;
    localparam int INST_W  = 8;

    typedef struct packed {
        decision_t            decision;
        reason_t              reason;
        logic [SEQ_W-1:0]     stored_prev;
        logic [SEQ_W-1:0]     claimed_prev;
        logic [SEQ_W-1:0]     applied_seq;
        logic                 resync_granted;
        logic                 entry_found;
        logic                 is_subscribed;
        logic                 has_sequence;
        logic                 resync_busy;
        logic [SEQ_W-1:0]     last_seq_out;
        logic [DEPTH_W-1:0]   depth_out;
    } rsp_t;

endpackage

### design/fsgt_req_if.sv
// Event channel into the sequence gap tracker
interface fsgt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [7:0]  instrument;
    logic [31:0] seq_number;
    logic [31:0] prev_seq_number;
    logic [15:0] depth_request;
    logic [15:0] snapshot_levels;
    logic        book_apply_ok;

    modport source (
        output valid, opcode, instrument, seq_number, prev_seq_number,
               depth_request, snapshot_levels, book_apply_ok,
        input  ready
    );
    modport sink (
        input  valid, opcode, instrument, seq_number, prev_seq_number,
               depth_request, snapshot_levels, book_apply_ok,
        output ready
    );
endinterface

### design/fsgt_rsp_if.sv
// Result channel out of the sequence gap tracker
interface fsgt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  decision;
    logic [2:0]  reason;
    logic [31:0] stored_prev;
    logic [31:0] claimed_prev;
    logic [31:0] applied_seq;
    logic        resync_granted;
    logic        entry_found;
    logic        is_subscribed;
    logic        has_sequence;
    logic        resync_busy;
    logic [31:0] last_seq_out;
    logic [15:0] depth_out;

    modport source (
        output valid, decision, reason, stored_prev, claimed_prev, applied_seq,
               resync_granted, entry_found, is_subscribed, has_sequence,
               resync_busy, last_seq_out, depth_out,
        input  ready
    );
    modport sink (
        input  valid, decision, reason, stored_prev, claimed_prev, applied_seq,
               resync_granted, entry_found, is_subscribed, has_sequence,
               resync_busy, last_seq_out, depth_out,
        output ready
    );
endinterface

### design/feed_sequence_gap_tracker_core.sv
// Feed sequence gap tracker: per-instrument sequence checking over a slot RAM
// An accepted item waits in stage 1 for its slot word, then its result is registered when the output is free.
// Throughput: one item per cycle unless rsp.ready holds the output; each item is one read-modify-write of the slot RAM,
// with the write forwarded when the next item names the same slot.
// Reset clears a per-slot valid flop vector at once; an unwritten slot reads as zero,
// so there is no clearing pass and items are taken as soon as reset is released.
`include "feed_sequence_gap_tracker_core_assert.svh"

module feed_sequence_gap_tracker_core #(
    parameter int INSTRUMENTS = 256,
    parameter int SEQ_BITS    = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    fsgt_req_if.sink    req,
    fsgt_rsp_if.source  rsp
);
    import fsgt_pkg::*;

    // only 256 indices are reachable through the 8-bit instrument field
    localparam int SLOTS = (INSTRUMENTS < 256) ? INSTRUMENTS : 256;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int SW    = (SEQ_BITS < SEQ_W) ? SEQ_BITS : SEQ_W;
    localparam logic [16:0] LIMIT = 17'(INSTRUMENTS);

    typedef struct packed {
        logic               present;
        logic               subscribed;
        logic               has_seq;
        logic               resync;
        logic [SW-1:0]      stored_seq;
        logic [DEPTH_W-1:0] depth;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    // stage 1: item waiting for its slot word
    logic                 s1_valid_reg;
    opcode_t              s1_op_reg;
    logic [INST_W-1:0]    s1_idx_reg;
    logic                 s1_in_range_reg;
    logic [SW-1:0]        s1_seq_reg;
    logic [SW-1:0]        s1_prev_reg;
    logic [DEPTH_W-1:0]   s1_dreq_reg;
    logic [DEPTH_W-1:0]   s1_levels_reg;
    logic                 s1_ok_reg;

    logic [SLOTS-1:0]     slot_valid_reg;
    logic                 rd_valid_reg;
    logic                 fwd_hit_reg;
    slot_t                fwd_slot_reg;

    logic                 rsp_valid_reg;
    rsp_t                 rsp_reg;
    rsp_t                 rsp_next;

    logic                 req_accept;
    logic                 advance;
    logic                 in_range;
    logic                 fwd_set;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     wr_addr;
    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_rdata;
    slot_t                cur_slot;
    slot_t                slot_next;
    logic                 present;

    assign advance    = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready  = !s1_valid_reg || advance;
    assign req_accept = req.valid && req.ready;
    assign in_range   = {9'd0, req.instrument} < LIMIT;
    assign rd_addr    = req.instrument[IDX_W-1:0];
    assign wr_addr    = s1_idx_reg[IDX_W-1:0];
    assign ram_we     = advance && s1_in_range_reg;
    // the older item writes the slot at the very edge the newer one reads it
    assign fwd_set    = req_accept && s1_valid_reg && s1_in_range_reg
                        && (req.instrument == s1_idx_reg);

    fsgt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (slot_next),
        .re    (req_accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (fwd_hit_reg)
        begin
            cur_slot = fwd_slot_reg;
        end
        else if (rd_valid_reg)
        begin
            cur_slot = slot_t'(ram_rdata);
        end
        else
        begin
            cur_slot = '0;
        end
    end

    assign present = s1_in_range_reg && cur_slot.present;

    always_comb
    begin
        slot_next = cur_slot;
        rsp_next  = '0;
        case (s1_op_reg)
            OP_SUBSCRIBE:
            begin
                if (s1_in_range_reg)
                begin
                    slot_next.present    = 1'b1;
                    slot_next.subscribed = 1'b1;
                    slot_next.depth      = s1_dreq_reg;
                end
            end
            OP_UNSUBSCRIBE:
            begin
                if (present)
                begin
                    slot_next.subscribed = 1'b0;
                    slot_next.has_seq    = 1'b0;
                    slot_next.resync     = 1'b0;
                    slot_next.stored_seq = '0;
                end
            end
            OP_SNAPSHOT:
            begin
                if (s1_in_range_reg)
                begin
                    slot_next.present    = 1'b1;
                    slot_next.subscribed = 1'b1;
                    slot_next.has_seq    = 1'b1;
                    slot_next.resync     = 1'b0;
                    slot_next.stored_seq = s1_seq_reg;
                    if (cur_slot.depth == '0)
                    begin
                        slot_next.depth = s1_levels_reg;
                    end
                end
            end
            OP_INCREMENTAL:
            begin
                if (!present || !cur_slot.subscribed)
                begin
                    rsp_next.decision = DEC_IGNORED;
                    rsp_next.reason   = RSN_NOT_SUBSCR;
                end
                else if (!cur_slot.has_seq)
                begin
                    rsp_next.decision = DEC_RESYNC;
                    rsp_next.reason   = RSN_NO_SNAPSHOT;
                end
                else if ((s1_seq_reg <= cur_slot.stored_seq)
                         || (s1_prev_reg != cur_slot.stored_seq) || !s1_ok_reg)
                begin
                    rsp_next.decision     = DEC_RESYNC;
                    rsp_next.stored_prev  = SEQ_W'(cur_slot.stored_seq);
                    rsp_next.claimed_prev = SEQ_W'(s1_prev_reg);
                    if (s1_seq_reg <= cur_slot.stored_seq)
                    begin
                        rsp_next.reason = RSN_OUT_OF_ORDER;
                    end
                    else if (s1_prev_reg != cur_slot.stored_seq)
                    begin
                        rsp_next.reason = RSN_GAP;
                    end
                    else
                    begin
                        rsp_next.reason = RSN_APPLY_FAILED;
                    end
                end
                else
                begin
                    slot_next.stored_seq = s1_seq_reg;
                    rsp_next.decision    = DEC_APPLIED;
                    rsp_next.reason      = RSN_APPLIED;
                    rsp_next.applied_seq = SEQ_W'(s1_seq_reg);
                end
            end
            OP_RESYNC_BEGIN:
            begin
                if (present && !cur_slot.resync)
                begin
                    slot_next.resync        = 1'b1;
                    rsp_next.resync_granted = 1'b1;
                end
            end
            OP_RESYNC_END:
            begin
                if (present)
                begin
                    slot_next.resync = 1'b0;
                end
            end
            OP_QUERY:
            begin
                if (present)
                begin
                    rsp_next.entry_found   = 1'b1;
                    rsp_next.is_subscribed = cur_slot.subscribed;
                    rsp_next.has_sequence  = cur_slot.has_seq;
                    rsp_next.resync_busy   = cur_slot.resync;
                    rsp_next.last_seq_out  = SEQ_W'(cur_slot.stored_seq);
                    rsp_next.depth_out     = cur_slot.depth;
                end
            end
            default:
            begin
                // unused opcode: no operation
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            slot_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
            fwd_hit_reg    <= 1'b0;
        end
        else
        begin
            if (req_accept)
            begin
                s1_valid_reg <= 1'b1;
                rd_valid_reg <= in_range && slot_valid_reg[rd_addr];
                fwd_hit_reg  <= fwd_set;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            if (ram_we)
            begin
                slot_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_op_reg       <= opcode_t'(req.opcode);
            s1_idx_reg      <= req.instrument;
            s1_in_range_reg <= in_range;
            s1_seq_reg      <= req.seq_number[SW-1:0];
            s1_prev_reg     <= req.prev_seq_number[SW-1:0];
            s1_dreq_reg     <= req.depth_request;
            s1_levels_reg   <= req.snapshot_levels;
            s1_ok_reg       <= req.book_apply_ok;
        end
        if (fwd_set)
        begin
            fwd_slot_reg <= slot_next;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.decision       = rsp_reg.decision;
    assign rsp.reason         = rsp_reg.reason;
    assign rsp.stored_prev    = rsp_reg.stored_prev;
    assign rsp.claimed_prev   = rsp_reg.claimed_prev;
    assign rsp.applied_seq    = rsp_reg.applied_seq;
    assign rsp.resync_granted = rsp_reg.resync_granted;
    assign rsp.entry_found    = rsp_reg.entry_found;
    assign rsp.is_subscribed  = rsp_reg.is_subscribed;
    assign rsp.has_sequence   = rsp_reg.has_sequence;
    assign rsp.resync_busy    = rsp_reg.resync_busy;
    assign rsp.last_seq_out   = rsp_reg.last_seq_out;
    assign rsp.depth_out      = rsp_reg.depth_out;

    // a new item only enters when the one in flight moves to the output
    `FSGT_ASSERT_IMPL(a_single_occupancy, req_accept && s1_valid_reg, advance)
    // a forwarded word is consumed by the very next item
    `FSGT_ASSERT_NEXT(a_fwd_consumed, fwd_set, s1_valid_reg && fwd_hit_reg)
    `FSGT_ASSERT_IMPL(a_applied_reason,
        rsp_valid_reg && (rsp_reg.decision == DEC_APPLIED),
        rsp_reg.reason == RSN_APPLIED)
    `FSGT_ASSERT_IMPL(a_grant_plain,
        rsp_valid_reg && rsp_reg.resync_granted,
        (rsp_reg.decision == DEC_NONE) && !rsp_reg.entry_found)

endmodule

### design/fsgt_ram.sv
// Generic single-write, single-read RAM with registered read data
module fsgt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
